>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/bplru_pkg.sv
// ----------------------------------------------------------------------------
// bplru_pkg
// Types and constants shared by the buffer pool frame manager.
// ----------------------------------------------------------------------------
package bplru_pkg;

   localparam int FRAME_COUNT_DEF = 16;
   localparam int PIN_BITS_DEF    = 8;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_NEW   = 2'd1;
   localparam logic [1:0] OP_UNPIN = 2'd2;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_LOADED    = 3'd1;
   localparam logic [2:0] ST_NOFRAME   = 3'd2;
   localparam logic [2:0] ST_UNPINNED  = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_UNUSED    = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_RO,
      S_PG,
      S_CMP,
      S_MISS,
      S_VRO,
      S_VCHK,
      S_SH_RD,
      S_SH_WR,
      S_LOAD,
      S_UNPIN,
      S_UNPIN2,
      S_OUT
   } state_type;

endpackage

>>> rtl/buffer_pool_lru_frame_manager.sv
// ----------------------------------------------------------------------------
// buffer_pool_lru_frame_manager
// Page frame bookkeeping with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The block handles one request word at a time and answers each with exactly
// one response word. A READ walks the recency order from the least recent
// end, and each frame inspected passes through a recency read, a page read
// and a compare. On a hit, each later occupied position of the recency
// order is read and written one place down, and the frame is then put at
// the most recent end. A READ miss first goes through the full lookup; after
// that, a pool that still has unused frames allocates the next one and
// loads it, while on a full pool the victim search reads the recency order
// and checks the pin count of each frame visited, then does the same shift
// and the load. NEW skips the lookup, and an unknown opcode answers like a
// failed allocation. The sequencer steps through the recency memory and
// the page memory, each with a single read port. The request side is ready
// only while the block is idle, and the response is held in output registers
// until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buffer_pool_lru_frame_manager
   import bplru_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int PIN_BITS    = PIN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_page_number,
   input  logic [3:0]  req_frame_index,
   input  logic        req_mark_dirty,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_frame_out,
   output logic [31:0] rsp_page_out,
   output logic        rsp_need_disk_read,
   output logic        rsp_need_zero_fill,
   output logic        rsp_need_flush
);

   localparam int FW = $clog2(FRAME_COUNT);
   localparam int UW = $clog2(FRAME_COUNT + 1);
   localparam int CW = (UW > 4) ? UW : 4;
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   // Sequencer state and the latched request word.
   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [31:0]       page_ff, page_in;
   logic [3:0]        fidx_ff, fidx_in;
   logic              mark_ff, mark_in;
   logic [FW-1:0]     pos_ff, pos_in;
   logic [FW-1:0]     frame_ff, frame_in;
   logic              hit_ff, hit_in;
   logic [UW-1:0]     used_ff, used_in;

   // Response registers.
   logic [2:0]        status_ff, status_in;
   logic [3:0]        fout_ff, fout_in;
   logic [31:0]       pout_ff, pout_in;
   logic              rd_ff, rd_in;
   logic              zf_ff, zf_in;
   logic              fl_ff, fl_in;

   // Per-frame pin counts and dirty marks, cleared by reset.
   logic [PIN_BITS-1:0] pin_ff [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] dirty_ff;
   logic                pin_we;
   logic [FW-1:0]       pin_idx;
   logic [PIN_BITS-1:0] pin_wdata;
   logic [PIN_BITS-1:0] pin_rd;
   logic                dirty_we;
   logic                dirty_wdata;

   // Memory ports.
   logic          ro_we;
   logic [FW-1:0] ro_waddr, ro_wdata, ro_raddr, ro_rdata;
   logic          pg_we;
   logic [FW-1:0] pg_waddr, pg_raddr;
   logic [31:0]   pg_wdata, pg_rdata;

   logic [CW-1:0] fidx_c, used_c;
   logic [UW-1:0] pos_next_u;
   logic          unpin_dirty;

   bplru_ram #(.WIDTH(FW), .DEPTH(FRAME_COUNT)) u_order (
      .clock  (clock),
      .wr_en  (ro_we),
      .wr_addr(ro_waddr),
      .wr_data(ro_wdata),
      .rd_addr(ro_raddr),
      .rd_data(ro_rdata)
   );

   bplru_ram #(.WIDTH(32), .DEPTH(FRAME_COUNT)) u_pages (
      .clock  (clock),
      .wr_en  (pg_we),
      .wr_addr(pg_waddr),
      .wr_data(pg_wdata),
      .rd_addr(pg_raddr),
      .rd_data(pg_rdata)
   );

   assign fidx_c      = CW'(fidx_ff);
   assign used_c      = CW'(used_ff);
   assign pos_next_u  = UW'(pos_ff) + UW'(1);
   assign pin_rd      = pin_ff[pin_idx];
   assign unpin_dirty = dirty_ff[pin_idx] | mark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            pin_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (pin_we) begin
            pin_ff[pin_idx] <= pin_wdata;
         end
         if (dirty_we) begin
            dirty_ff[pin_idx] <= dirty_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      page_ff   <= page_in;
      fidx_ff   <= fidx_in;
      mark_ff   <= mark_in;
      pos_ff    <= pos_in;
      frame_ff  <= frame_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      fout_ff   <= fout_in;
      pout_ff   <= pout_in;
      rd_ff     <= rd_in;
      zf_ff     <= zf_in;
      fl_ff     <= fl_in;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      page_in     = page_ff;
      fidx_in     = fidx_ff;
      mark_in     = mark_ff;
      pos_in      = pos_ff;
      frame_in    = frame_ff;
      hit_in      = hit_ff;
      used_in     = used_ff;
      status_in   = status_ff;
      fout_in     = fout_ff;
      pout_in     = pout_ff;
      rd_in       = rd_ff;
      zf_in       = zf_ff;
      fl_in       = fl_ff;
      pin_we      = 1'b0;
      pin_idx     = frame_ff;
      pin_wdata   = '0;
      dirty_we    = 1'b0;
      dirty_wdata = 1'b0;
      ro_we       = 1'b0;
      ro_waddr    = pos_ff;
      ro_wdata    = ro_rdata;
      ro_raddr    = pos_ff;
      pg_we       = 1'b0;
      pg_waddr    = frame_ff;
      pg_wdata    = page_ff;
      pg_raddr    = frame_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               page_in  = req_page_number;
               fidx_in  = req_frame_index;
               mark_in  = req_mark_dirty;
               state_in = S_START;
            end
         end
         S_START: begin
            pos_in = '0;
            hit_in = 1'b0;
            priority if (op_ff == OP_READ) begin
               state_in = (used_ff == '0) ? S_MISS : S_RO;
            end else if (op_ff == OP_NEW) begin
               state_in = S_MISS;
            end else if (op_ff == OP_UNPIN) begin
               state_in = S_UNPIN;
            end else begin
               // Unknown opcode answers like a failed allocation.
               status_in = ST_NOFRAME;
               fout_in   = '0;
               pout_in   = '0;
               rd_in     = 1'b0;
               zf_in     = 1'b0;
               fl_in     = 1'b0;
               state_in  = S_OUT;
            end
         end
         S_RO: begin
            state_in = S_PG;
         end
         S_PG: begin
            frame_in = ro_rdata;
            pg_raddr = ro_rdata;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (pg_rdata == page_ff) begin
               if (pin_rd != PIN_MAX) begin
                  pin_we    = 1'b1;
                  pin_wdata = pin_rd + PIN_BITS'(1);
               end
               hit_in   = 1'b1;
               state_in = S_SH_RD;
            end else if (pos_next_u == used_ff) begin
               state_in = S_MISS;
            end else begin
               pos_in   = pos_ff + FW'(1);
               state_in = S_RO;
            end
         end
         S_MISS: begin
            if (UW'(FRAME_COUNT) != used_ff) begin
               // Unused frames are handed out in index order.
               frame_in = FW'(used_ff);
               ro_we    = 1'b1;
               ro_waddr = FW'(used_ff);
               ro_wdata = FW'(used_ff);
               used_in  = used_ff + UW'(1);
               state_in = S_LOAD;
            end else begin
               pos_in   = '0;
               state_in = S_VRO;
            end
         end
         S_VRO: begin
            state_in = S_VCHK;
         end
         S_VCHK: begin
            pin_idx = ro_rdata;
            if (pin_rd == '0) begin
               frame_in = ro_rdata;
               state_in = S_SH_RD;
            end else if (pos_ff == FW'(FRAME_COUNT - 1)) begin
               status_in = ST_NOFRAME;
               fout_in   = '0;
               pout_in   = '0;
               rd_in     = 1'b0;
               zf_in     = 1'b0;
               fl_in     = 1'b0;
               state_in  = S_OUT;
            end else begin
               pos_in   = pos_ff + FW'(1);
               state_in = S_VRO;
            end
         end
         S_SH_RD: begin
            if (pos_next_u < used_ff) begin
               ro_raddr = FW'(pos_next_u);
               state_in = S_SH_WR;
            end else begin
               // The chosen frame goes to the most recent end.
               ro_we    = 1'b1;
               ro_waddr = FW'(used_ff - UW'(1));
               ro_wdata = frame_ff;
               if (hit_ff) begin
                  status_in = ST_HIT;
                  fout_in   = 4'(frame_ff);
                  pout_in   = page_ff;
                  rd_in     = 1'b0;
                  zf_in     = 1'b0;
                  fl_in     = 1'b0;
                  state_in  = S_OUT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_SH_WR: begin
            ro_we    = 1'b1;
            ro_waddr = pos_ff;
            ro_wdata = ro_rdata;
            pos_in   = pos_ff + FW'(1);
            state_in = S_SH_RD;
         end
         S_LOAD: begin
            pg_we       = 1'b1;
            pin_we      = 1'b1;
            pin_wdata   = PIN_BITS'(1);
            dirty_we    = 1'b1;
            dirty_wdata = 1'b0;
            status_in   = ST_LOADED;
            fout_in     = 4'(frame_ff);
            pout_in     = page_ff;
            rd_in       = (op_ff == OP_READ);
            zf_in       = (op_ff == OP_NEW);
            fl_in       = 1'b0;
            state_in    = S_OUT;
         end
         S_UNPIN: begin
            if (fidx_c >= used_c) begin
               status_in = ST_UNUSED;
               fout_in   = fidx_ff;
               pout_in   = '0;
               rd_in     = 1'b0;
               zf_in     = 1'b0;
               fl_in     = 1'b0;
               state_in  = S_OUT;
            end else begin
               frame_in = FW'(fidx_ff);
               pg_raddr = FW'(fidx_ff);
               state_in = S_UNPIN2;
            end
         end
         S_UNPIN2: begin
            dirty_we    = 1'b1;
            dirty_wdata = unpin_dirty;
            fout_in     = fidx_ff;
            pout_in     = pg_rdata;
            rd_in       = 1'b0;
            zf_in       = 1'b0;
            if (pin_rd == '0) begin
               status_in = ST_UNDERFLOW;
               fl_in     = 1'b0;
            end else begin
               pin_we    = 1'b1;
               pin_wdata = pin_rd - PIN_BITS'(1);
               status_in = ST_UNPINNED;
               fl_in     = (pin_rd == PIN_BITS'(1)) && unpin_dirty;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_status         = status_ff;
   assign rsp_frame_out      = fout_ff;
   assign rsp_page_out       = pout_ff;
   assign rsp_need_disk_read = rd_ff;
   assign rsp_need_zero_fill = zf_ff;
   assign rsp_need_flush     = fl_ff;

   // The pool never reports more used frames than it has.
   `ASSERT_CLK_RST(a_used_bound, clock, reset, used_ff <= UW'(FRAME_COUNT), "frame count over pool size")
   // Frames once used stay used.
   `ASSERT_CLK_RST(a_used_grows, clock, reset, !$past(reset) |-> used_ff >= $past(used_ff), "frame count fell")
   // An accepted request closes the request side until its response is taken.
   `ASSERT_CLK_RST(a_busy, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready while busy")
   // A loaded frame asks for exactly one of disk read or zero fill.
   `ASSERT_CLK_RST(a_load_kind, clock, reset, (rsp_valid && rsp_status == ST_LOADED) |-> (rsp_need_disk_read != rsp_need_zero_fill), "load kind wrong")

endmodule

>>> rtl/bplru_ram.sv
// ----------------------------------------------------------------------------
// bplru_ram
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bplru_ram
   import bplru_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = FRAME_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
